// ===== hdl/sqm_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, codes and control types of the subsequence query matcher.
// No dependencies.
package sqm_pkg;

  localparam int SEQ_DEPTH  = 1024;
  localparam int VALUE_BITS = 20;
  localparam int ADDR_BITS  = (SEQ_DEPTH > 1) ? $clog2(SEQ_DEPTH) : 1;
  localparam int LEN_BITS   = $clog2(SEQ_DEPTH + 1);
  localparam int KIND_BITS  = 2;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_APPEND  = 2'd0,
    KIND_ELEMENT = 2'd1,
    KIND_END     = 2'd2,
    KIND_CLEAR   = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic append;
    logic clear;
    logic start_elem;
    logic issue;
    logic take_hit;
    logic mark_fail;
    logic end_query;
    logic emit;
  } sqm_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic exhausted;
    logic failed;
  } sqm_sts_t;

endpackage

// ===== hdl/sqm_ifs.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the matcher's input and result streams.
// Depends on sqm_pkg.
interface sqm_in_if;
  import sqm_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [KIND_BITS-1:0]  kind;
  logic [VALUE_BITS-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink   (input valid, input kind, input value, output ready);
endinterface

interface sqm_out_if;
  logic valid;
  logic ready;
  logic is_subsequence;

  modport source (output valid, output is_subsequence, input ready);
  modport sink   (input valid, input is_subsequence, output ready);
endinterface

// ===== hdl/sqm_datapath.sv =====
`timescale 1ns / 1ps
// Datapath: sequence memory, length and search registers, scan pointer and
// compare, result and output payload. Depends on sqm_pkg.
module sqm_datapath (
  input  logic                          clk,
  input  logic                          rst,
  input  sqm_pkg::sqm_cmd_t             cmd,
  input  logic [sqm_pkg::VALUE_BITS-1:0] value,
  output sqm_pkg::sqm_sts_t             sts,
  output logic                          out_bit
);
  import sqm_pkg::*;

  logic [VALUE_BITS-1:0] mem [SEQ_DEPTH];
  logic [VALUE_BITS-1:0] rd_data;
  logic [VALUE_BITS-1:0] elem;
  logic [LEN_BITS-1:0]   length;
  logic [LEN_BITS-1:0]   search_start;
  logic [LEN_BITS-1:0]   ptr;
  logic [LEN_BITS-1:0]   rd_pos;
  logic                  rd_pend;
  logic                  failed;
  logic                  result;
  logic                  not_full;

  assign not_full = length < LEN_BITS'(SEQ_DEPTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      length       <= '0;
      search_start <= '0;
      failed       <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      rd_pend <= cmd.issue;
      if (cmd.append && not_full) begin
        length <= length + LEN_BITS'(1);
      end
      if (cmd.take_hit) begin
        search_start <= rd_pos + LEN_BITS'(1);
      end
      if (cmd.mark_fail) begin
        failed <= 1'b1;
      end
      if (cmd.clear || cmd.end_query) begin
        search_start <= '0;
        failed       <= 1'b0;
      end
      if (cmd.clear) begin
        length <= '0;
      end
    end
  end

  // sequence memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.append && not_full) begin
      mem[length[ADDR_BITS-1:0]] <= value;
    end
    if (cmd.issue) begin
      rd_data <= mem[ptr[ADDR_BITS-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_elem) begin
      elem <= value;
      ptr  <= search_start;
    end else if (cmd.issue) begin
      ptr <= ptr + LEN_BITS'(1);
    end
    if (cmd.issue) begin
      rd_pos <= ptr;
    end
    if (cmd.end_query) begin
      result <= !failed;
    end
    if (cmd.emit) begin
      out_bit <= result;
    end
  end

  assign sts.hit       = rd_pend && (rd_data == elem);
  assign sts.exhausted = ptr >= length;
  assign sts.failed    = failed;

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    length <= LEN_BITS'(SEQ_DEPTH))
    else $error("sequence length beyond depth");

  a_read_written: assert property (@(posedge clk) disable iff (rst)
    rd_pend |-> rd_pos < length)
    else $error("scan read an entry never appended");

  a_start_moves: assert property (@(posedge clk) disable iff (rst)
    cmd.take_hit |=> search_start > $past(search_start))
    else $error("search start did not advance on a hit");

endmodule

// ===== hdl/sqm_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: decodes input beats, sequences the element scan and the
// result hand-off, owns the output valid flag. Depends on sqm_pkg.
module sqm_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic [sqm_pkg::KIND_BITS-1:0] in_kind,
  output logic                          in_ready,
  output logic                          out_valid,
  input  logic                          out_ready,
  input  sqm_pkg::sqm_sts_t             sts,
  output sqm_pkg::sqm_cmd_t             cmd
);
  import sqm_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  kind_t  kind;

  assign kind = kind_t'(in_kind);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          case (kind)
            KIND_APPEND: cmd.append = 1'b1;
            KIND_CLEAR:  cmd.clear  = 1'b1;
            KIND_ELEMENT: begin
              // a failed query stays failed: skip the scan
              if (!sts.failed) begin
                cmd.start_elem = 1'b1;
                state_next     = ST_SCAN;
              end
            end
            KIND_END: begin
              cmd.end_query = 1'b1;
              state_next    = ST_EMIT;
            end
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        if (sts.hit) begin
          cmd.take_hit = 1'b1;
          state_next   = ST_IDLE;
        end else if (sts.exhausted) begin
          cmd.mark_fail = 1'b1;
          state_next    = ST_IDLE;
        end else begin
          cmd.issue = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid || out_ready) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("result beat not presented after emit");

  a_scan_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> !sts.failed)
    else $error("scan running on a failed query");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |-> !cmd.emit)
    else $error("pending result beat overwritten");

endmodule

// ===== hdl/subsequence_query_matcher.sv =====
`timescale 1ns / 1ps
// Greedy subsequence matcher. An end beat closes the query and then loads
// the output result bit, waiting while an earlier result beat is not yet
// accepted. A query element scans the stored sequence from the entry after
// the last match through the single read port of the sequence memory, one
// entry per cycle, until an entry matches or the stored entries run out.
// Elements after a miss skip the scan. Store contents need no clearing after
// reset; only entries below the current length are ever read. Depends on
// sqm_pkg, sqm_ifs.
module subsequence_query_matcher (
  input logic       clk,
  input logic       rst,
  sqm_in_if.sink    in_ch,
  sqm_out_if.source out_ch
);
  import sqm_pkg::*;

  sqm_cmd_t cmd;
  sqm_sts_t sts;

  sqm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_kind   (in_ch.kind),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sqm_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .value   (in_ch.value),
    .sts     (sts),
    .out_bit (out_ch.is_subsequence)
  );

endmodule
